[hw/rtl/spq_pkg.sv]
package spq_pkg;

   localparam int DEFAULT_CAPACITY  = 16;
   localparam int DEFAULT_PRIO_BITS = 8;

   localparam int PORT_PRIO_W = 8;
   localparam int CHAR_W      = 8;
   localparam int COUNT_W     = 5;

   typedef enum logic {
      KIND_ENQ = 1'b0,
      KIND_DEQ = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic enq;
      logic deq;
   } cell_ctl_type;

endpackage

[hw/rtl/spq_intf.sv]
interface spq_req_if
   import spq_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic                   kind;
   logic [PORT_PRIO_W-1:0] new_prio;
   logic [CHAR_W-1:0]      new_char;

   modport source (output valid, kind, new_prio, new_char, input ready);
   modport sink   (input valid, kind, new_prio, new_char, output ready);
endinterface

interface spq_rsp_if
   import spq_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic                   out_valid;
   logic [PORT_PRIO_W-1:0] out_prio;
   logic [CHAR_W-1:0]      out_char;
   logic [1:0]             status;
   logic [COUNT_W-1:0]     count;

   modport source (output valid, out_valid, out_prio, out_char, status, count, input ready);
   modport sink   (input valid, out_valid, out_prio, out_char, status, count, output ready);
endinterface

[hw/rtl/spq_cell.sv]
module spq_cell
   import spq_pkg::*;
#(
   parameter int PRIO_BITS = DEFAULT_PRIO_BITS
) (
   input  logic                 clock,
   input  cell_ctl_type         ctl,
   input  logic                 occupied,
   input  logic [PRIO_BITS-1:0] new_prio,
   input  logic [CHAR_W-1:0]    new_char,
   input  logic                 left_mark,
   input  logic [PRIO_BITS-1:0] left_prio,
   input  logic [CHAR_W-1:0]    left_char,
   input  logic [PRIO_BITS-1:0] right_prio,
   input  logic [CHAR_W-1:0]    right_char,
   output logic                 mark,
   output logic [PRIO_BITS-1:0] prio,
   output logic [CHAR_W-1:0]    char_out
);

   logic [PRIO_BITS-1:0] prio_ff, prio_in;
   logic [CHAR_W-1:0]    char_ff, char_in;

   // A cell is marked when the new entry belongs at or before it.
   assign mark = !occupied || (prio_ff > new_prio);

   always_comb begin
      prio_in = prio_ff;
      char_in = char_ff;
      if (ctl.enq && mark) begin
         if (left_mark) begin
            prio_in = left_prio;
            char_in = left_char;
         end else begin
            prio_in = new_prio;
            char_in = new_char;
         end
      end else if (ctl.deq) begin
         prio_in = right_prio;
         char_in = right_char;
      end
   end

   always_ff @(posedge clock) begin
      prio_ff <= prio_in;
      char_ff <= char_in;
   end

   assign prio     = prio_ff;
   assign char_out = char_ff;

endmodule

[hw/rtl/sorted_priority_queue_unit.sv]
// Sorted priority queue of up to CAPACITY (priority, character) entries held in a row
// of cells in ascending priority order. Every request gets exactly one response, registered
// in the cycle after it is accepted; a new request is accepted in every cycle in which the
// response register is empty or being taken, so the queue sustains one request per
// cycle. All cells compare the new priority against their own entry in parallel and
// then shift right (enqueue) or left (dequeue) in the same cycle. Equal priorities
// leave in arrival order. Enqueue while full and dequeue while empty report a status
// code and leave the queue unchanged. The count field carries the low five bits of
// the number of held entries.
module sorted_priority_queue_unit
   import spq_pkg::*;
#(
   parameter int CAPACITY  = DEFAULT_CAPACITY,
   parameter int PRIO_BITS = DEFAULT_PRIO_BITS
) (
   input  logic      clock,
   input  logic      reset,
   spq_req_if.sink   req_bus,
   spq_rsp_if.source rsp_bus
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 full, empty, accept;
   cell_ctl_type         ctl;
   logic [PRIO_BITS-1:0] new_prio;

   logic [PRIO_BITS-1:0] prio_w [CAPACITY];
   logic [CHAR_W-1:0]    char_w [CAPACITY];
   logic                 mark_w [CAPACITY];

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   out_valid_ff, out_valid_in;
   logic [PORT_PRIO_W-1:0] out_prio_ff, out_prio_in;
   logic [CHAR_W-1:0]      out_char_ff, out_char_in;
   status_type             status_ff, status_in;
   logic [COUNT_W-1:0]     count_ff, count_in;

   assign full     = (cnt_ff == CNT_W'(CAPACITY));
   assign empty    = (cnt_ff == '0);
   assign accept   = req_bus.valid && req_bus.ready;
   assign new_prio = PRIO_BITS'(req_bus.new_prio);

   assign ctl.enq = accept && (req_bus.kind == KIND_ENQ) && !full;
   assign ctl.deq = accept && (req_bus.kind == KIND_DEQ) && !empty;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                 left_mark, occupied;
      logic [PRIO_BITS-1:0] left_prio, right_prio;
      logic [CHAR_W-1:0]    left_char, right_char;

      assign occupied = (CNT_W'(i) < cnt_ff);

      if (i == 0) begin : g_first
         assign left_mark = 1'b0;
         assign left_prio = new_prio;
         assign left_char = req_bus.new_char;
      end else begin : g_inner
         assign left_mark = mark_w[i-1];
         assign left_prio = prio_w[i-1];
         assign left_char = char_w[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_prio = prio_w[i];
         assign right_char = char_w[i];
      end else begin : g_mid
         assign right_prio = prio_w[i+1];
         assign right_char = char_w[i+1];
      end

      spq_cell #(
         .PRIO_BITS (PRIO_BITS)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .occupied   (occupied),
         .new_prio   (new_prio),
         .new_char   (req_bus.new_char),
         .left_mark  (left_mark),
         .left_prio  (left_prio),
         .left_char  (left_char),
         .right_prio (right_prio),
         .right_char (right_char),
         .mark       (mark_w[i]),
         .prio       (prio_w[i]),
         .char_out   (char_w[i])
      );
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (ctl.enq) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (ctl.deq) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = accept || (rsp_valid_ff && !rsp_bus.ready);
      out_valid_in = out_valid_ff;
      out_prio_in  = out_prio_ff;
      out_char_in  = out_char_ff;
      status_in    = status_ff;
      count_in     = count_ff;
      if (accept) begin
         out_valid_in = ctl.deq;
         out_prio_in  = ctl.deq ? PORT_PRIO_W'(prio_w[0]) : '0;
         out_char_in  = ctl.deq ? char_w[0] : '0;
         count_in     = COUNT_W'(cnt_in);
         if (req_bus.kind == KIND_ENQ && full) begin
            status_in = STATUS_FULL;
         end else if (req_bus.kind == KIND_DEQ && empty) begin
            status_in = STATUS_EMPTY;
         end else begin
            status_in = STATUS_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_valid_ff <= out_valid_in;
      out_prio_ff  <= out_prio_in;
      out_char_ff  <= out_char_in;
      status_ff    <= status_in;
      count_ff     <= count_in;
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.out_valid = out_valid_ff;
   assign rsp_bus.out_prio  = out_prio_ff;
   assign rsp_bus.out_char  = out_char_ff;
   assign rsp_bus.status    = status_ff;
   assign rsp_bus.count     = count_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(CAPACITY))
      else $error("entry count exceeds capacity");

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted request produced no response");

   a_deq_delivers: assert property (@(posedge clock) disable iff (reset)
      ctl.deq |=> (out_valid_ff && status_ff == STATUS_OK))
      else $error("dequeue of a nonempty queue delivered nothing");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      accept |=> (count_ff == COUNT_W'(cnt_ff)))
      else $error("reported count differs from held count");

   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff >= CNT_W'(2)) |-> (prio_w[0] <= prio_w[1]))
      else $error("head entries out of order");

endmodule

[dv/sorted_priority_queue_unit_test.sv]
module sorted_priority_queue_unit_test
   import spq_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY    = DEFAULT_CAPACITY;
   localparam int PRIO_BITS   = DEFAULT_PRIO_BITS;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PRINT_LIMIT = 40;

   typedef struct {
      logic                   out_valid;
      logic [PORT_PRIO_W-1:0] out_prio;
      logic [CHAR_W-1:0]      out_char;
      status_type             status;
      logic [COUNT_W-1:0]     count;
   } queue_response_type;

   logic clock = 1'b0;
   logic reset;

   spq_req_if req_bus ();
   spq_rsp_if rsp_bus ();

   sorted_priority_queue_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #6 clock = ~clock;

   logic [PORT_PRIO_W-1:0] held_prio [CAPACITY];
   logic [CHAR_W-1:0]      held_char [CAPACITY];
   int                     held_count = 0;
   queue_response_type     pending_responses [$];

   int error_count = 0;
   int cycle_count = 0;
   int hold_cycles = 0;
   bit sender_idle_on = 1'b1;
   bit receiver_idle_on = 1'b1;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("sorted_priority_queue_unit test failed");
         $finish;
      end
   end

   task automatic report_mismatch(string what);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("cycle %0d: %s", cycle_count, what);
   endtask

   function automatic queue_response_type apply_request(kind_type op,
                                                        logic [PORT_PRIO_W-1:0] prio_in,
                                                        logic [CHAR_W-1:0] char_in);
      queue_response_type     r;
      int                     slot;
      logic [PORT_PRIO_W-1:0] prio;
      logic [PORT_PRIO_W-1:0] prio_mask;
      prio_mask   = PORT_PRIO_W'((64'd1 << PRIO_BITS) - 1);
      prio        = prio_in & prio_mask;
      r.out_valid = 1'b0;
      r.out_prio  = '0;
      r.out_char  = '0;
      r.status    = STATUS_OK;
      if (op == KIND_ENQ) begin
         if (held_count >= CAPACITY) begin
            r.status = STATUS_FULL;
         end else begin
            slot = held_count;
            for (int k = 0; k < held_count; k++) begin
               if (held_prio[k] > prio) begin
                  slot = k;
                  break;
               end
            end
            for (int k = held_count; k > slot; k--) begin
               held_prio[k] = held_prio[k-1];
               held_char[k] = held_char[k-1];
            end
            held_prio[slot] = prio;
            held_char[slot] = char_in;
            held_count++;
         end
      end else begin
         if (held_count == 0) begin
            r.status = STATUS_EMPTY;
         end else begin
            r.out_valid = 1'b1;
            r.out_prio  = held_prio[0];
            r.out_char  = held_char[0];
            for (int k = 1; k < held_count; k++) begin
               held_prio[k-1] = held_prio[k];
               held_char[k-1] = held_char[k];
            end
            held_count--;
         end
      end
      r.count = COUNT_W'(held_count);
      return r;
   endfunction

   task automatic check_response();
      queue_response_type want;
      if (pending_responses.size() == 0) begin
         report_mismatch("response arrived with no request outstanding");
         return;
      end
      want = pending_responses.pop_front();
      if (rsp_bus.out_valid !== want.out_valid)
         report_mismatch($sformatf("out_valid %0b, expected %0b",
                                   rsp_bus.out_valid, want.out_valid));
      if (rsp_bus.out_prio !== want.out_prio)
         report_mismatch($sformatf("out_prio %0d, expected %0d",
                                   rsp_bus.out_prio, want.out_prio));
      if (rsp_bus.out_char !== want.out_char)
         report_mismatch($sformatf("out_char %0d, expected %0d",
                                   rsp_bus.out_char, want.out_char));
      if (rsp_bus.status !== want.status)
         report_mismatch($sformatf("status %0d, expected %0d",
                                   rsp_bus.status, want.status));
      if (rsp_bus.count !== want.count)
         report_mismatch($sformatf("count %0d, expected %0d",
                                   rsp_bus.count, want.count));
   endtask

   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready)
         pending_responses.push_back(apply_request(kind_type'(req_bus.kind),
                                                   req_bus.new_prio, req_bus.new_char));
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         check_response();
   end

   initial begin
      rsp_bus.ready <= 1'b0;
      @(posedge clock iff !reset);
      forever begin
         if (hold_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end else if (receiver_idle_on && $urandom_range(0, 2) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   task automatic send_request(kind_type op, logic [PORT_PRIO_W-1:0] prio,
                               logic [CHAR_W-1:0] ch);
      if (sender_idle_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.kind     <= op;
      req_bus.new_prio <= prio;
      req_bus.new_char <= ch;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic send_random(int enq_percent, bit tight_prio);
      kind_type               op;
      logic [PORT_PRIO_W-1:0] prio;
      op   = ($urandom_range(0, 99) < enq_percent) ? KIND_ENQ : KIND_DEQ;
      prio = tight_prio ? PORT_PRIO_W'($urandom_range(0, 3))
                        : PORT_PRIO_W'($urandom_range(0, 255));
      send_request(op, prio, CHAR_W'($urandom_range(0, 255)));
   endtask

   task automatic test_dequeue_empty();
      send_request(KIND_DEQ, 8'h00, 8'h00);
      send_request(KIND_DEQ, 8'hff, 8'hff);
   endtask

   task automatic test_fill_to_capacity();
      logic [PORT_PRIO_W-1:0] prios [CAPACITY] = '{8'd255, 8'd0, 8'd128, 8'd0,
                                                   8'd255, 8'd1, 8'd128, 8'd254,
                                                   8'd0, 8'd127, 8'd128, 8'd255,
                                                   8'd64, 8'd1, 8'd0, 8'd200};
      for (int k = 0; k < CAPACITY; k++)
         send_request(KIND_ENQ, prios[k], (k % 2 == 0) ? CHAR_W'(8'hff - k) : CHAR_W'(k));
   endtask

   task automatic test_enqueue_full();
      send_request(KIND_ENQ, 8'h00, 8'haa);
      send_request(KIND_ENQ, 8'hff, 8'h55);
   endtask

   task automatic test_dequeue_order();
      repeat (5) send_request(KIND_DEQ, 8'hff, 8'h00);
   endtask

   task automatic test_random_mix();
      int enq_percent;
      for (int seg = 0; seg < 18; seg++) begin
         case (seg % 3)
            0: enq_percent = 80;
            1: enq_percent = 20;
            default: enq_percent = 50;
         endcase
         repeat (40) send_random(enq_percent, $urandom_range(0, 2) == 0);
      end
   endtask

   task automatic test_backpressure();
      hold_cycles = 300;
      repeat (60) send_random(50, 1'b0);
   endtask

   task automatic test_without_idling();
      sender_idle_on   = 1'b0;
      receiver_idle_on = 1'b0;
      repeat (3) begin
         repeat (30) send_random(85, $urandom_range(0, 1) == 0);
         repeat (30) send_random(15, 1'b0);
      end
   endtask

   initial begin
      req_bus.valid    <= 1'b0;
      req_bus.kind     <= KIND_ENQ;
      req_bus.new_prio <= '0;
      req_bus.new_char <= '0;
      reset            <= 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_dequeue_empty();
      test_fill_to_capacity();
      test_enqueue_full();
      test_dequeue_order();
      test_random_mix();
      test_backpressure();
      test_without_idling();

      req_bus.valid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (pending_responses.size() != 0)
         report_mismatch("requests left without a response");

      if (error_count == 0) begin
         $display("sorted_priority_queue_unit test passed");
      end else begin
         $display("sorted_priority_queue_unit test failed");
      end
      $finish;
   end
endmodule
